// ===== design/ptt_pkg.sv =====
// Package for the periodic timer table: command and status codes and the
// control struct that the controller hands to the datapath.
// Depends on nothing; every other file of the block uses it.
package ptt_pkg;

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_DEREGISTER = 2'd1,
        CMD_SET_IVL    = 2'd2,
        CMD_TICK       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2
    } t_status;

    localparam int unsigned SLOT_FIELD_W = 4;
    localparam int unsigned MAX_SLOTS    = 16;
    localparam int unsigned PORT_TIME_W  = 32;

    typedef struct packed {
        logic accept;   // a beat is taken this cycle
        logic exec;     // carry out a non-tick command on the latched beat
        logic scan;     // evaluate the slot at the scan index
        logic flush;    // close the tick with the final result
    } t_ctl;

endpackage

// ===== design/ptt_controller.sv =====
// Controller state machine of the periodic timer table.
// Depends on ptt_pkg; drives the ptt_datapath through a ptt_pkg::t_ctl struct.
module ptt_controller #(
    parameter  int NUM_SLOTS = 16,
    localparam int EFF       = (NUM_SLOTS < ptt_pkg::MAX_SLOTS) ? NUM_SLOTS : ptt_pkg::MAX_SLOTS,
    localparam int SW_OUT    = (EFF > 1) ? $clog2(EFF) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_command,
    output logic                busy,
    output ptt_pkg::t_ctl       o_ctl,
    output logic [SW_OUT-1:0]   o_idx
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [SW_OUT-1:0]   r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.accept = 1'b1;
                    n_idx        = '0;
                    if (ptt_pkg::t_cmd'(i_command) == ptt_pkg::CMD_TICK) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (r_idx == SW_OUT'(EFF - 1)) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FLUSH: begin
                o_ctl.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_idx = r_idx;

endmodule

// ===== design/ptt_datapath.sv =====
// Datapath of the periodic timer table: slot memories, valid bits, the
// command latch, due-time arithmetic and the result register.
// Depends on ptt_pkg; steered by ptt_controller.
module ptt_datapath #(
    parameter  int NUM_SLOTS  = 16,
    parameter  int TIME_WIDTH = 32,
    localparam int EFF        = (NUM_SLOTS < ptt_pkg::MAX_SLOTS) ? NUM_SLOTS : ptt_pkg::MAX_SLOTS,
    localparam int SW_IN      = (EFF > 1) ? $clog2(EFF) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptt_pkg::t_ctl        i_ctl,
    input  logic [SW_IN-1:0]     i_idx,
    input  logic [1:0]           i_command,
    input  logic [3:0]           i_slot,
    input  logic [31:0]          i_interval,
    input  logic                 i_wait_first,
    input  logic [31:0]          i_time_now,
    output logic                 o_strobe,
    output logic [1:0]           o_status,
    output logic [3:0]           o_result_slot,
    output logic                 o_fired,
    output logic                 o_last
);
    localparam int DEPTH = 1 << SW_IN;
    localparam int TW    = TIME_WIDTH;

    // Latched beat.
    ptt_pkg::t_cmd  r_cmd;
    logic [3:0]     r_slot;
    logic [TW-1:0]  r_ivl;
    logic           r_wait;
    logic [TW-1:0]  r_now;

    // Slot store.
    logic [DEPTH-1:0] r_valid, n_valid;
    logic [TW-1:0]    mem_int [DEPTH];
    logic [TW-1:0]    mem_due [DEPTH];
    logic [TW-1:0]    r_rd_int, r_rd_due;
    logic [SW_IN-1:0] rd_addr;

    logic             int_we, due_we;
    logic [SW_IN-1:0] wr_addr;
    logic [TW-1:0]    int_wd, due_wd;

    // Firing held back until it is known whether another one follows.
    logic             r_pend, n_pend;
    logic [SW_IN-1:0] r_pend_slot, n_pend_slot;

    // Result register.
    logic             r_strobe, n_strobe;
    logic [1:0]       r_status, n_status;
    logic [3:0]       r_rslot, n_rslot;
    logic             r_fired, n_fired;
    logic             r_last, n_last;

    logic [SW_IN-1:0] slot_lo;
    logic             slot_ok;
    logic             free_found;
    logic [SW_IN-1:0] free_idx;
    logic             fire;

    assign slot_lo = r_slot[SW_IN-1:0];
    assign slot_ok = ({1'b0, r_slot} < 5'(EFF)) && r_valid[slot_lo];
    assign fire    = r_valid[i_idx] && (r_now >= r_rd_due);

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = EFF - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = SW_IN'(i);
            end
        end
    end

    // Read address: beat slot (slot 0 for a tick), else the slot after the scan index.
    always_comb begin
        if (i_ctl.accept) begin
            if (ptt_pkg::t_cmd'(i_command) == ptt_pkg::CMD_TICK) begin
                rd_addr = '0;
            end else begin
                rd_addr = i_slot[SW_IN-1:0];
            end
        end else if (i_idx == SW_IN'(EFF - 1)) begin
            rd_addr = '0;
        end else begin
            rd_addr = i_idx + 1'b1;
        end
    end

    always_comb begin
        n_valid     = r_valid;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_strobe    = 1'b0;
        n_status    = ptt_pkg::ST_OK;
        n_rslot     = '0;
        n_fired     = 1'b0;
        n_last      = 1'b1;
        int_we      = 1'b0;
        due_we      = 1'b0;
        wr_addr     = slot_lo;
        int_wd      = r_ivl;
        due_wd      = r_rd_due + (r_ivl - r_rd_int);

        if (i_ctl.accept) begin
            n_pend = 1'b0;
        end

        if (i_ctl.exec) begin
            n_strobe = 1'b1;
            unique case (r_cmd)
                ptt_pkg::CMD_REGISTER: begin
                    if (free_found) begin
                        n_valid[free_idx] = 1'b1;
                        int_we            = 1'b1;
                        due_we            = 1'b1;
                        wr_addr           = free_idx;
                        due_wd            = r_now + (r_wait ? r_ivl : '0);
                        n_rslot           = 4'(free_idx);
                    end else begin
                        n_status = ptt_pkg::ST_FULL;
                    end
                end
                ptt_pkg::CMD_DEREGISTER: begin
                    if (slot_ok) begin
                        n_valid[slot_lo] = 1'b0;
                    end else begin
                        n_status = ptt_pkg::ST_NOT_USED;
                    end
                end
                ptt_pkg::CMD_SET_IVL: begin
                    if (slot_ok) begin
                        int_we = 1'b1;
                        due_we = 1'b1;
                    end else begin
                        n_status = ptt_pkg::ST_NOT_USED;
                    end
                end
                ptt_pkg::CMD_TICK: begin
                    // A tick never reaches this step; it goes through the scan.
                    n_strobe = 1'b0;
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end

        if (i_ctl.scan && fire) begin
            due_we      = 1'b1;
            wr_addr     = i_idx;
            due_wd      = r_now + r_rd_int;
            n_pend      = 1'b1;
            n_pend_slot = i_idx;
            if (r_pend) begin
                n_strobe = 1'b1;
                n_rslot  = 4'(r_pend_slot);
                n_fired  = 1'b1;
                n_last   = 1'b0;
            end
        end

        if (i_ctl.flush) begin
            n_strobe = 1'b1;
            n_pend   = 1'b0;
            if (r_pend) begin
                n_rslot = 4'(r_pend_slot);
                n_fired = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd  <= ptt_pkg::t_cmd'(i_command);
            r_slot <= i_slot;
            r_ivl  <= TW'(i_interval);
            r_wait <= i_wait_first;
            r_now  <= TW'(i_time_now);
        end
        r_pend_slot <= n_pend_slot;
        r_status    <= n_status;
        r_rslot     <= n_rslot;
        r_fired     <= n_fired;
        r_last      <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (int_we) begin
            mem_int[wr_addr] <= int_wd;
        end
        if (due_we) begin
            mem_due[wr_addr] <= due_wd;
        end
        r_rd_int <= mem_int[rd_addr];
        r_rd_due <= mem_due[rd_addr];
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_result_slot = r_rslot;
    assign o_fired       = r_fired;
    assign o_last        = r_last;

endmodule

// ===== design/periodic_timer_table_core.sv =====
// Top level of the periodic timer table: joins the controller and the datapath.
// Depends on ptt_pkg, ptt_controller and ptt_datapath.
//
// Usage. A command beat is taken at a rising edge where start is high and busy
// is low; it carries the command, slot, interval, wait flag and time. Results
// leave one at a time on the o_ ports, each marked by o_strobe for exactly one
// cycle; the receiver has no way to hold them off, so it must take every one.
// o_last marks the final result of a beat.
// Register, deregister and set interval: busy during the exec state, where the
// single result is registered; it shows as busy falls, and the next beat may be
// offered in the cycle the result shows.
// Tick: the controller scans the min(NUM_SLOTS, 16) slots one slot per cycle
// through the interval and due memories (one read and one write port each),
// then closes the tick in its flush state. A firing is reported once the next
// firing or the end of the scan is known, so results of a tick arrive during
// the scan and the last one just after it.
// A synchronous reset, active low, frees every slot and drops any result in
// flight; interval and due entries are not cleared, as a free slot is never read.
module periodic_timer_table_core #(
    parameter int NUM_SLOTS  = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_interval,
    input  logic        i_wait_first,
    input  logic [31:0] i_time_now,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [3:0]  o_result_slot,
    output logic        o_fired,
    output logic        o_last
);
    // The table never holds more than sixteen slots: a result names a slot in four bits.
    localparam int EFF = (NUM_SLOTS < ptt_pkg::MAX_SLOTS) ? NUM_SLOTS : ptt_pkg::MAX_SLOTS;
    localparam int SW  = (EFF > 1) ? $clog2(EFF) : 1;

    ptt_pkg::t_ctl ctl;
    logic [SW-1:0] scan_idx;

    // The controller sequences beats and the tick scan.
    ptt_controller #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .busy      (busy),
        .o_ctl     (ctl),
        .o_idx     (scan_idx)
    );

    // The datapath holds the slots and forms every result.
    ptt_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_idx         (scan_idx),
        .i_command     (i_command),
        .i_slot        (i_slot),
        .i_interval    (i_interval),
        .i_wait_first  (i_wait_first),
        .i_time_now    (i_time_now),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_result_slot (o_result_slot),
        .o_fired       (o_fired),
        .o_last        (o_last)
    );

endmodule

// ===== design/ptt_checker.sv =====
// Port-level checks for the periodic timer table, bound to its top level.
// Depends on ptt_pkg and on periodic_timer_table_core's ports.
module ptt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_command,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic        o_fired,
    input logic        o_last
);

    // A result that is not the last of its beat comes while the block is still busy.
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("non-final result shown while idle");

    // After a non-tick beat the block is busy in the exec state, then gives its single final result with busy low.
    a_cmd_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command != ptt_pkg::CMD_TICK))
        |=> busy ##1 (o_strobe && o_last && !busy))
        else $error("command result not on time");

    // A firing is always reported with status ok.
    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_fired) |-> (o_status == ptt_pkg::ST_OK))
        else $error("firing reported with an error status");

    // An error result stands alone and reports no firing.
    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ptt_pkg::ST_OK)) |-> (o_last && !o_fired))
        else $error("error result not final or marked fired");

endmodule

bind periodic_timer_table_core ptt_checker u_ptt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_command (i_command),
    .o_strobe  (o_strobe),
    .o_status  (o_status),
    .o_fired   (o_fired),
    .o_last    (o_last)
);

// ===== tb/sv/periodic_timer_table_core_tb.sv =====
// Self-checking testbench for periodic_timer_table_core: directed and random command
// beats, checked against a behavioural timer table held in the bench itself.
// Depends on ptt_pkg and the periodic_timer_table_core RTL.
module periodic_timer_table_core_tb;

    // The table holds min(NUM_SLOTS, 16) slots; the block is built at its default of 16.
    localparam int TABLE_SLOTS  = 16;
    // Longer than a tick takes, so this is plenty to let the last one settle.
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 6;
    // The slowest legal run is roughly 500 beats plus long sender gaps; the limit is
    // taken many times over that.
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        ptt_pkg::t_status status;
        logic [3:0]       slot;
        logic             fired;
        logic             last;
    } t_timer_result;

    // Clock, reset and the command side of the block. Every input has a known value
    // from time zero.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  i_command    = ptt_pkg::CMD_TICK;
    logic [3:0]  i_slot       = '0;
    logic [31:0] i_interval   = '0;
    logic        i_wait_first = 1'b0;
    logic [31:0] i_time_now   = '0;
    logic        busy;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [3:0]  o_result_slot;
    logic        o_fired;
    logic        o_last;

    // The bench's own picture of the timer table.
    bit          slot_in_use [TABLE_SLOTS];
    logic [31:0] slot_period [TABLE_SLOTS];
    logic [31:0] slot_due    [TABLE_SLOTS];

    // Results that the block owes us, oldest first.
    t_timer_result pending_results[$];

    int          n_failures      = 0;
    int          cycle_count     = 0;
    int          sender_idle_pct = 0;
    logic [31:0] cur_time        = '0;

    periodic_timer_table_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_slot        (i_slot),
        .i_interval    (i_interval),
        .i_wait_first  (i_wait_first),
        .i_time_now    (i_time_now),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_result_slot (o_result_slot),
        .o_fired       (o_fired),
        .o_last        (o_last)
    );

    // A period of four time units: two high, two low.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog. Should the block stop answering, the run is ended here rather than
    // hanging for ever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_result(input ptt_pkg::t_status status, input int slot,
                                input logic fired, input logic last);
        t_timer_result res;
        res.status = status;
        res.slot   = slot[3:0];
        res.fired  = fired;
        res.last   = last;
        pending_results.push_back(res);
    endtask

    // Works out what one accepted beat does to the table and which results it owes.
    task automatic timer_table_predict(input ptt_pkg::t_cmd cmd, input logic [3:0] sl,
                                       input logic [31:0] ivl, input logic wait_flag,
                                       input logic [31:0] now);
        int i;
        int free_slot;
        int final_fire;
        bit fire_now [TABLE_SLOTS];
        free_slot  = -1;
        final_fire = -1;
        case (cmd)
            ptt_pkg::CMD_REGISTER: begin
                // The lowest free slot is taken; with none left the table is full and
                // nothing changes.
                for (i = TABLE_SLOTS - 1; i >= 0; i--) begin
                    if (!slot_in_use[i]) free_slot = i;
                end
                if (free_slot < 0) begin
                    queue_result(ptt_pkg::ST_FULL, 0, 1'b0, 1'b1);
                end else begin
                    slot_in_use[free_slot] = 1'b1;
                    slot_period[free_slot] = ivl;
                    slot_due[free_slot]    = wait_flag ? now + ivl : now;
                    queue_result(ptt_pkg::ST_OK, free_slot, 1'b0, 1'b1);
                end
            end
            ptt_pkg::CMD_DEREGISTER, ptt_pkg::CMD_SET_IVL: begin
                if (int'(sl) >= TABLE_SLOTS || !slot_in_use[sl]) begin
                    queue_result(ptt_pkg::ST_NOT_USED, 0, 1'b0, 1'b1);
                end else begin
                    if (cmd == ptt_pkg::CMD_DEREGISTER) begin
                        slot_in_use[sl] = 1'b0;
                    end else begin
                        // The due time moves by the change of period, wrapping at 32 bits.
                        slot_due[sl]    = slot_due[sl] + (ivl - slot_period[sl]);
                        slot_period[sl] = ivl;
                    end
                    queue_result(ptt_pkg::ST_OK, 0, 1'b0, 1'b1);
                end
            end
            default: begin
                // Tick: first find every slot that is due, so that the final firing can
                // carry the last flag, then rearm and report them in ascending order.
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    fire_now[i] = slot_in_use[i] && (now >= slot_due[i]);
                    if (fire_now[i]) final_fire = i;
                end
                if (final_fire < 0) begin
                    queue_result(ptt_pkg::ST_OK, 0, 1'b0, 1'b1);
                end else begin
                    for (i = 0; i < TABLE_SLOTS; i++) begin
                        if (fire_now[i]) begin
                            slot_due[i] = now + slot_period[i];
                            queue_result(ptt_pkg::ST_OK, i, 1'b1, i == final_fire);
                        end
                    end
                end
            end
        endcase
    endtask

    // Offers one command beat and returns once the block has taken it. Start stays high
    // unless the sender chooses to idle, so back-to-back beats leave no gap.
    task automatic send_beat(input ptt_pkg::t_cmd cmd, input logic [3:0] sl,
                             input logic [31:0] ivl, input logic wait_flag,
                             input logic [31:0] now);
        start        <= 1'b1;
        i_command    <= cmd;
        i_slot       <= sl;
        i_interval   <= ivl;
        i_wait_first <= wait_flag;
        i_time_now   <= now;
        // The beat is taken at the first edge at which busy was low.
        do @(posedge i_clk); while (busy !== 1'b0);
        timer_table_predict(cmd, sl, ivl, wait_flag, now);
        // Idling right after the beat lands the gaps in whatever phase of its work the
        // block has reached, including the middle of a tick scan.
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Result checker. The receiver cannot hold results off, so every cycle with the
    // strobe high is one result beat, compared with the oldest one still owed. The
    // outputs are read at the edge, before the block updates them.
    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_results.size() == 0) begin
                if (n_failures < MAX_REPORTS) begin
                    $display("%0t: stray result: status %0d slot %0d fired %b last %b",
                             $time, o_status, o_result_slot, o_fired, o_last);
                end
                n_failures++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_result_slot !== want.slot ||
                        o_fired !== want.fired || o_last !== want.last) begin
                    if (n_failures < MAX_REPORTS) begin
                        $write("%0t: mismatch: expected status %0d slot %0d fired %b last %b",
                               $time, want.status, want.slot, want.fired, want.last);
                        $display(", got status %0d slot %0d fired %b last %b",
                                 o_status, o_result_slot, o_fired, o_last);
                    end
                    n_failures++;
                end
            end
        end
    end

    // Reset is applied once, at the start of the run, and then released.
    task automatic reset_dut;
        int i;
        for (i = 0; i < TABLE_SLOTS; i++) slot_in_use[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // An empty table: a tick reports no firing, and a deregister or set interval of a
    // free slot is refused.
    task automatic test_empty_table;
        send_beat(ptt_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0, 32'd0);
        send_beat(ptt_pkg::CMD_DEREGISTER, 4'd0, 32'd0, 1'b0, 32'd0);
        send_beat(ptt_pkg::CMD_SET_IVL, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    endtask

    // Every slot is taken, with the extremes of the period and the time among them, and
    // one more register then finds the table full.
    task automatic test_fill_table;
        int i;
        send_beat(ptt_pkg::CMD_REGISTER, 4'd15, 32'd0, 1'b0, 32'd0);
        // The due time here wraps round to one below the top of the range.
        send_beat(ptt_pkg::CMD_REGISTER, 4'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        for (i = 2; i < TABLE_SLOTS; i++) begin
            send_beat(ptt_pkg::CMD_REGISTER, 4'($urandom_range(15)),
                      32'($urandom_range(1, 24)), 1'($urandom_range(1)), $urandom);
        end
        send_beat(ptt_pkg::CMD_REGISTER, 4'd0, 32'd5, 1'b0, 32'd0);
    endtask

    // A tick at the top of the time range finds every slot due, which gives the longest
    // run of results from one beat.
    task automatic test_tick_all_fire;
        send_beat(ptt_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    endtask

    // Changing a period, freeing a slot, freeing it twice and taking it back again.
    task automatic test_slot_updates;
        send_beat(ptt_pkg::CMD_SET_IVL, 4'd0, 32'hFFFF_FFFF, 1'b0, 32'd0);
        send_beat(ptt_pkg::CMD_DEREGISTER, 4'd15, 32'd0, 1'b0, 32'd0);
        send_beat(ptt_pkg::CMD_DEREGISTER, 4'd15, 32'd0, 1'b0, 32'd0);
        send_beat(ptt_pkg::CMD_REGISTER, 4'd3, 32'd7, 1'b1, 32'd100);
    endtask

    // Random traffic. The time moves forward in small steps with short periods so that
    // slots fire often, with the odd jump to any 32-bit value. Most deregister and set
    // interval beats address a slot in use; the rest hit any slot, free ones included.
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        int            pick;
        int            reg_pct;
        int            i;
        int            in_use[$];
        ptt_pkg::t_cmd cmd;
        logic [3:0]    sl;
        logic [31:0]   ivl;
        logic [31:0]   now;
        logic          wait_flag;
        sender_idle_pct = idle_pct;
        repeat (n_items) begin
            in_use.delete();
            for (i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_in_use[i]) in_use.push_back(i);
            end
            // Registering eases off once the table is nearly full, so that the
            // occupancy wanders about in the upper half and now and then reaches full.
            reg_pct = (in_use.size() >= 12) ? 12 : 35;
            pick    = $urandom_range(99);
            if (pick < reg_pct) begin
                cmd = ptt_pkg::CMD_REGISTER;
            end else if (pick < reg_pct + 20) begin
                cmd = ptt_pkg::CMD_DEREGISTER;
            end else if (pick < reg_pct + 35) begin
                cmd = ptt_pkg::CMD_SET_IVL;
            end else begin
                cmd = ptt_pkg::CMD_TICK;
            end

            case ($urandom_range(9))
                0:       ivl = 32'd0;
                1:       ivl = $urandom;
                default: ivl = 32'($urandom_range(1, 24));
            endcase
            if (in_use.size() > 0 && $urandom_range(4) != 0) begin
                sl = 4'(in_use[$urandom_range(in_use.size() - 1)]);
            end else begin
                sl = 4'($urandom_range(15));
            end
            wait_flag = 1'($urandom_range(1));

            if (cmd == ptt_pkg::CMD_TICK) begin
                if ($urandom_range(19) == 0) begin
                    cur_time = $urandom;
                end else begin
                    cur_time = cur_time + 32'($urandom_range(0, 8));
                end
                now = cur_time;
            end else if ($urandom_range(9) == 0) begin
                now = $urandom;
            end else begin
                now = cur_time;
            end
            send_beat(cmd, sl, ivl, wait_flag, now);
        end
    endtask

    initial begin
        reset_dut();
        test_empty_table();
        test_fill_table();
        test_tick_all_fire();
        test_slot_updates();
        // The sender idles lightly, then heavily, then not at all.
        test_random_traffic(150, 15);
        test_random_traffic(150, 79);
        test_random_traffic(160, 0);
        start <= 1'b0;
        // Wait for every owed result, then give the block time to show any stray one.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_failures == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
